>>> src/stx_etx_tag_frame_parser_unit_defines.svh
// ---------------------------------------------------------------------------
// stx_etx_tag_frame_parser_unit_defines
// Assertion macros used by the checker file of the frame parser. Each
// macro expands to one labeled concurrent assertion that is clocked on clk_i
// and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef STX_ETX_TAG_FRAME_PARSER_UNIT_DEFINES_SVH
`define STX_ETX_TAG_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define STX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define STX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/stx_pkg.sv
// ---------------------------------------------------------------------------
// stx_pkg
// Shared codes, state types and queue entry types of the STX/ETX frame parser.
// ---------------------------------------------------------------------------
package stx_pkg;

  // Framing and type bytes on the serial line.
  localparam logic [7:0] BYTE_START = 8'h02;
  localparam logic [7:0] BYTE_END   = 8'h03;
  localparam logic [7:0] TYPE_ID    = 8'h39;
  localparam logic [7:0] TYPE_DATA  = 8'h32;

  // Width of the byte position field on the result port.
  localparam int unsigned PosW = 6;

  // Receive side framing phase.
  typedef enum logic [1:0] {
    PhHunt    = 2'd0,
    PhType    = 2'd1,
    PhPayload = 2'd2,
    PhEnd     = 2'd3
  } phase_e;

  // Emit side sequencer state.
  typedef enum logic [1:0] {
    BkIdle = 2'd0,
    BkRead = 2'd1,
    BkShow = 2'd2
  } back_state_e;

  // One completed frame: which buffer bank holds it and its kind.
  typedef struct packed {
    logic bank;
    logic kind;
  } frame_t;

  // Frame hand-off from the receive side into the queue.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } push_t;

  // Bank release from the emit side once a frame is fully delivered.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

>>> src/stx_front.sv
// ---------------------------------------------------------------------------
// stx_front
// Receive side: tracks the framing phase, writes payload bytes into the
// current buffer bank and hands a completed frame to the queue.
// ---------------------------------------------------------------------------
module stx_front #(
  parameter int unsigned ID_LENGTH   = 8,
  parameter int unsigned DATA_LENGTH = 34,
  parameter int unsigned IdxW        = 6,
  parameter int unsigned CntW        = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 we_o,
  output logic [IdxW:0]        waddr_o,
  output logic [7:0]           wdata_o,
  output stx_pkg::push_t       push_o,
  input  stx_pkg::release_t    release_i
);

  stx_pkg::phase_e phase_q, phase_d;
  logic            kind_q, kind_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            bank_q, bank_d;
  logic [1:0]      busy_q, busy_d;

  logic            acc;
  logic            push;
  logic [CntW-1:0] len;
  logic [CntW-1:0] cnt_inc;

  // A bank stays busy until the emit side has delivered its frame.
  assign in_stall_o = busy_q[bank_q];
  assign acc        = in_valid_i & ~in_stall_o;
  assign len        = kind_q ? CntW'(DATA_LENGTH) : CntW'(ID_LENGTH);
  assign cnt_inc    = cnt_q + CntW'(1);

  // Next framing state.
  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    cnt_d   = cnt_q;
    bank_d  = bank_q;
    if (acc) begin
      unique case (phase_q)
        stx_pkg::PhHunt: begin
          if (rx_byte_i == stx_pkg::BYTE_START) begin
            phase_d = stx_pkg::PhType;
          end
        end
        stx_pkg::PhType: begin
          if (rx_byte_i == stx_pkg::TYPE_ID || rx_byte_i == stx_pkg::TYPE_DATA) begin
            kind_d  = (rx_byte_i == stx_pkg::TYPE_DATA);
            cnt_d   = '0;
            phase_d = stx_pkg::PhPayload;
          end else if (rx_byte_i == stx_pkg::BYTE_START) begin
            phase_d = stx_pkg::PhType;
          end else begin
            phase_d = stx_pkg::PhHunt;
          end
        end
        stx_pkg::PhPayload: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= len) begin
            phase_d = stx_pkg::PhEnd;
          end
        end
        stx_pkg::PhEnd: begin
          cnt_d = '0;
          if (rx_byte_i == stx_pkg::BYTE_END) begin
            phase_d = stx_pkg::PhHunt;
            bank_d  = ~bank_q;
          end else if (rx_byte_i == stx_pkg::BYTE_START) begin
            phase_d = stx_pkg::PhType;
          end else begin
            phase_d = stx_pkg::PhHunt;
          end
        end
        default: phase_d = stx_pkg::PhHunt;
      endcase
    end
  end

  // Buffer write and frame hand-off.
  always_comb begin
    push              = acc && (phase_q == stx_pkg::PhEnd) && (rx_byte_i == stx_pkg::BYTE_END);
    we_o              = acc && (phase_q == stx_pkg::PhPayload);
    waddr_o           = {bank_q, cnt_q[IdxW-1:0]};
    wdata_o           = rx_byte_i;
    push_o.valid      = push;
    push_o.frame.bank = bank_q;
    push_o.frame.kind = kind_q;
  end

  // Bank occupancy: set on hand-off, cleared on release.
  always_comb begin
    busy_d = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (push) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= stx_pkg::PhHunt;
      kind_q  <= 1'b0;
      cnt_q   <= '0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

>>> src/stx_fifo.sv
// ---------------------------------------------------------------------------
// stx_fifo
// Two-entry queue of completed frames between the receive and emit sides.
// ---------------------------------------------------------------------------
module stx_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stx_pkg::push_t   push_i,
  input  logic             pop_i,
  output logic             valid_o,
  output stx_pkg::frame_t  head_o
);

  stx_pkg::frame_t ent_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      count_q;

  assign valid_o = (count_q != 2'd0);
  assign head_o  = ent_q[rd_ptr_q];

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      ent_q[wr_ptr_q] <= push_i.frame;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i.valid) - 2'(pop_i && valid_o);
    end
  end

endmodule

>>> src/stx_store.sv
// ---------------------------------------------------------------------------
// stx_store
// Two-bank payload buffer: one write port, one registered read port.
// ---------------------------------------------------------------------------
module stx_store #(
  parameter int unsigned AddrW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [2**AddrW];
  logic [7:0] rdata_q;

  assign rdata_o = rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

>>> src/stx_back.sv
// ---------------------------------------------------------------------------
// stx_back
// Emit side: takes a frame from the queue, reads its bank byte by byte and
// presents each byte on the result port, then releases the bank.
// ---------------------------------------------------------------------------
module stx_back #(
  parameter int unsigned ID_LENGTH   = 8,
  parameter int unsigned DATA_LENGTH = 34,
  parameter int unsigned IdxW        = 6,
  parameter int unsigned CntW        = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  stx_pkg::frame_t             q_frame_i,
  output logic                        pop_o,
  output logic                        re_o,
  output logic [IdxW:0]               raddr_o,
  input  logic [7:0]                  rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        frame_kind_o,
  output logic [7:0]                  payload_byte_o,
  output logic [stx_pkg::PosW-1:0]    byte_position_o,
  output logic                        last_of_frame_o,
  output stx_pkg::release_t           release_o
);

  stx_pkg::back_state_e state_q, state_d;
  stx_pkg::frame_t      fr_q;
  logic [IdxW-1:0]      idx_q;

  logic [CntW-1:0]      len;
  logic                 last;
  logic                 beat;

  assign len  = fr_q.kind ? CntW'(DATA_LENGTH) : CntW'(ID_LENGTH);
  assign last = (CntW'(idx_q) + CntW'(1)) == len;
  assign beat = (state_q == stx_pkg::BkShow) && !out_stall_i;

  // Next sequencer state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stx_pkg::BkIdle: begin
        if (q_valid_i) begin
          state_d = stx_pkg::BkRead;
        end
      end
      stx_pkg::BkRead: state_d = stx_pkg::BkShow;
      stx_pkg::BkShow: begin
        if (!out_stall_i) begin
          state_d = last ? stx_pkg::BkIdle : stx_pkg::BkRead;
        end
      end
      default: state_d = stx_pkg::BkIdle;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop_o           = (state_q == stx_pkg::BkIdle) && q_valid_i;
    re_o            = (state_q == stx_pkg::BkRead);
    raddr_o         = {fr_q.bank, idx_q};
    out_valid_o     = (state_q == stx_pkg::BkShow);
    frame_kind_o    = fr_q.kind;
    payload_byte_o  = rdata_i;
    byte_position_o = stx_pkg::PosW'(idx_q);
    last_of_frame_o = last;
    release_o.valid = beat && last;
    release_o.bank  = fr_q.bank;
  end

  // Frame descriptor and byte index.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      fr_q  <= q_frame_i;
      idx_q <= '0;
    end else if (beat && !last) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stx_pkg::BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/stx_etx_tag_frame_parser_unit.sv
// Input: one byte per cycle; stalls only while both payload banks hold frames.
// Hand-off: with the emit side idle, a frame is registered into the queue at the end byte beat,
// then popped by the emit sequencer, which reads its first payload byte from the buffer and shows it.
// Output: each byte is read from the buffer, then shown; the next read waits until the shown byte is taken.
// Reset: asynchronous, active low; clears framing phase, queue and bank flags.
// Buffer contents are not cleared; every entry is written before it is read.
// ---------------------------------------------------------------------------
// stx_etx_tag_frame_parser_unit
// STX/ETX frame parser: collects identifier or data frames from a byte
// stream into a two-bank buffer and emits each complete payload byte by byte.
// ---------------------------------------------------------------------------
module stx_etx_tag_frame_parser_unit #(
  parameter int unsigned ID_LENGTH   = 8,
  parameter int unsigned DATA_LENGTH = 34
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      frame_kind_o,
  output logic [7:0]                payload_byte_o,
  output logic [stx_pkg::PosW-1:0]  byte_position_o,
  output logic                      last_of_frame_o
);

  localparam int unsigned StoreDepth = (ID_LENGTH > DATA_LENGTH) ? ID_LENGTH : DATA_LENGTH;
  localparam int unsigned IdxW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);

  logic              we;
  logic [IdxW:0]     waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [IdxW:0]     raddr;
  logic [7:0]        rdata;
  logic              pop;
  logic              q_valid;
  stx_pkg::frame_t   q_head;
  stx_pkg::push_t    push;
  stx_pkg::release_t rel;

  stx_front #(
    .ID_LENGTH  (ID_LENGTH),
    .DATA_LENGTH(DATA_LENGTH),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .rx_byte_i (rx_byte_i),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .push_o    (push),
    .release_i (rel)
  );

  stx_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .valid_o(q_valid),
    .head_o (q_head)
  );

  stx_store #(
    .AddrW(IdxW + 1)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  stx_back #(
    .ID_LENGTH  (ID_LENGTH),
    .DATA_LENGTH(DATA_LENGTH),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_frame_i      (q_head),
    .pop_o          (pop),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_kind_o   (frame_kind_o),
    .payload_byte_o (payload_byte_o),
    .byte_position_o(byte_position_o),
    .last_of_frame_o(last_of_frame_o),
    .release_o      (rel)
  );

endmodule

>>> src/stx_checker.sv
// ---------------------------------------------------------------------------
// stx_checker
// Port-level checks of the result stream of the frame parser.
// ---------------------------------------------------------------------------
`include "stx_etx_tag_frame_parser_unit_defines.svh"

module stx_checker #(
  parameter int unsigned ID_LENGTH   = 8,
  parameter int unsigned DATA_LENGTH = 34
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      frame_kind_o,
  input logic [7:0]                payload_byte_o,
  input logic [stx_pkg::PosW-1:0]  byte_position_o,
  input logic                      last_of_frame_o
);

  logic [stx_pkg::PosW-1:0]  exp_pos_q;
  logic                      kind_q;
  logic [stx_pkg::PosW-1:0]  last_pos;
  logic                      beat;
  logic                      stalled;
  logic                      mid_frame;
  logic                      last_ok;
  logic [stx_pkg::PosW+9:0]  res_bits;

  assign beat      = out_valid_o && !out_stall_i;
  assign stalled   = out_valid_o && out_stall_i;
  assign mid_frame = out_valid_o && (exp_pos_q != '0);
  assign last_pos  = frame_kind_o ? stx_pkg::PosW'(DATA_LENGTH - 1)
                                  : stx_pkg::PosW'(ID_LENGTH - 1);
  assign last_ok   = last_of_frame_o == (byte_position_o == last_pos);
  assign res_bits  = {frame_kind_o, payload_byte_o, byte_position_o, last_of_frame_o};

  // Track the expected position and kind of the next result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pos_q <= '0;
      kind_q    <= 1'b0;
    end else if (beat) begin
      exp_pos_q <= last_of_frame_o ? '0 : byte_position_o + stx_pkg::PosW'(1);
      kind_q    <= frame_kind_o;
    end
  end

  // A stalled result beat holds its payload.
  `STX_ASSERT_NXT(a_hold, stalled, out_valid_o && $stable(res_bits), "stalled result changed")

  // Positions run from zero without gaps.
  `STX_ASSERT_IMP(a_pos, out_valid_o, byte_position_o == exp_pos_q, "position out of sequence")

  // The last mark sits exactly on the final position of the frame kind.
  `STX_ASSERT_IMP(a_last, out_valid_o, last_ok, "last mark misplaced")

  // All bytes of one frame carry the same kind.
  `STX_ASSERT_IMP(a_kind, mid_frame, frame_kind_o == kind_q, "frame kind changed mid-frame")

endmodule

bind stx_etx_tag_frame_parser_unit stx_checker #(
  .ID_LENGTH  (ID_LENGTH),
  .DATA_LENGTH(DATA_LENGTH)
) u_stx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .frame_kind_o   (frame_kind_o),
  .payload_byte_o (payload_byte_o),
  .byte_position_o(byte_position_o),
  .last_of_frame_o(last_of_frame_o)
);

>>> tb/sv/stx_etx_tag_frame_parser_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stx_etx_tag_frame_parser_unit_tb
// Self-checking bench for the STX/ETX frame parser. Bytes are pushed through
// the input channel while a local model of the framing rules predicts every
// payload beat. A checker compares each delivered beat with the oldest
// prediction. Traffic runs with and without source gaps and sink stalls.
// ---------------------------------------------------------------------------
module stx_etx_tag_frame_parser_unit_tb;

  localparam int unsigned IdLen     = 8;
  localparam int unsigned DataLen   = 34;
  localparam int unsigned CycleCap  = 400000;
  localparam int unsigned TailWait  = 20;

  // One expected payload beat on the result channel.
  typedef struct packed {
    logic                       kind;
    logic [7:0]                 data;
    logic [stx_pkg::PosW-1:0]   pos;
    logic                       last;
  } payload_beat_t;

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic [7:0]                 rx_byte_i       = 8'h00;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic                       frame_kind_o;
  logic [7:0]                 payload_byte_o;
  logic [stx_pkg::PosW-1:0]   byte_position_o;
  logic                       last_of_frame_o;

  // Framing model state.
  stx_pkg::phase_e   rx_phase;
  logic              held_kind;
  int unsigned       stored_count;
  logic [7:0]        frame_store [64];
  payload_beat_t     pending_beats [$];

  int unsigned       gap_pct;
  int unsigned       stall_pct;
  int unsigned       live_bytes;
  int unsigned       cycle_count;
  int unsigned       error_count;

  stx_etx_tag_frame_parser_unit #(
    .ID_LENGTH   (IdLen),
    .DATA_LENGTH (DataLen)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_kind_o    (frame_kind_o),
    .payload_byte_o  (payload_byte_o),
    .byte_position_o (byte_position_o),
    .last_of_frame_o (last_of_frame_o)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Sink stalls are redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Advances the framing model by one accepted byte and queues any beats.
  function automatic void predict_byte(input logic [7:0] b);
    int unsigned len;
    if (rx_phase != stx_pkg::PhHunt || b == stx_pkg::BYTE_START) live_bytes++;
    len = held_kind ? DataLen : IdLen;
    case (rx_phase)
      stx_pkg::PhHunt: begin
        if (b == stx_pkg::BYTE_START) rx_phase = stx_pkg::PhType;
      end
      stx_pkg::PhType: begin
        if (b == stx_pkg::TYPE_ID || b == stx_pkg::TYPE_DATA) begin
          held_kind    = (b == stx_pkg::TYPE_DATA);
          stored_count = 0;
          rx_phase     = stx_pkg::PhPayload;
        end else if (b == stx_pkg::BYTE_START) begin
          rx_phase = stx_pkg::PhType;
        end else begin
          rx_phase = stx_pkg::PhHunt;
        end
      end
      stx_pkg::PhPayload: begin
        frame_store[stored_count[5:0]] = b;
        stored_count++;
        if (stored_count >= len) rx_phase = stx_pkg::PhEnd;
      end
      default: begin
        if (b == stx_pkg::BYTE_END) begin
          for (int unsigned k = 0; k < len; k++) begin
            pending_beats.push_back(payload_beat_t'{kind: held_kind,
                                                    data: frame_store[k[5:0]],
                                                    pos: k[stx_pkg::PosW-1:0],
                                                    last: (k + 1 == len)});
          end
          rx_phase = stx_pkg::PhHunt;
        end else begin
          rx_phase = (b == stx_pkg::BYTE_START) ? stx_pkg::PhType : stx_pkg::PhHunt;
        end
        stored_count = 0;
      end
    endcase
  endfunction

  // Compares each delivered beat with the oldest prediction.
  always @(posedge clk_i) begin : beat_checker
    payload_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: expected no beat, actual kind=%0d byte=%02h pos=%0d last=%0d", $time,
                 frame_kind_o, payload_byte_o, byte_position_o, last_of_frame_o);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        if (frame_kind_o !== want.kind) begin
          $display("%0t: frame_kind expected %0d actual %0d", $time, want.kind, frame_kind_o);
          error_count++;
        end
        if (payload_byte_o !== want.data) begin
          $display("%0t: payload_byte expected %02h actual %02h", $time, want.data,
                   payload_byte_o);
          error_count++;
        end
        if (byte_position_o !== want.pos) begin
          $display("%0t: byte_position expected %0d actual %0d", $time, want.pos,
                   byte_position_o);
          error_count++;
        end
        if (last_of_frame_o !== want.last) begin
          $display("%0t: last_of_frame expected %0d actual %0d", $time, want.last,
                   last_of_frame_o);
          error_count++;
        end
      end
    end
  end

  // Offers one byte after a random gap and holds it until it is taken.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b);
  endtask

  // Stops the source until every predicted beat has been delivered.
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
  endtask

  // Random payload content, biased toward the framing and type codes.
  function automatic logic [7:0] pick_payload();
    logic [7:0] b;
    case ($urandom_range(9))
      0:       b = stx_pkg::BYTE_START;
      1:       b = stx_pkg::BYTE_END;
      2:       b = ($urandom_range(1) != 0) ? stx_pkg::TYPE_ID : stx_pkg::TYPE_DATA;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // Sends a complete frame of the given kind closed by the given byte.
  task automatic send_frame(input logic kind, input logic [7:0] close_byte);
    int unsigned len;
    len = kind ? DataLen : IdLen;
    send_byte(stx_pkg::BYTE_START);
    send_byte(kind ? stx_pkg::TYPE_DATA : stx_pkg::TYPE_ID);
    repeat (len) send_byte(pick_payload());
    send_byte(close_byte);
  endtask

  // Bytes other than the start byte are ignored while hunting.
  task automatic test_hunt_ignores_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(stx_pkg::BYTE_END);
  endtask

  // Identifier frame carrying extreme values and framing codes as payload.
  task automatic test_id_frame_extremes();
    send_byte(stx_pkg::BYTE_START);
    send_byte(stx_pkg::TYPE_ID);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(stx_pkg::BYTE_START);
    send_byte(stx_pkg::BYTE_END);
    send_byte(stx_pkg::TYPE_ID);
    send_byte(stx_pkg::TYPE_DATA);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(stx_pkg::BYTE_END);
  endtask

  // An unknown type byte drops the frame; a start byte there restarts it.
  task automatic test_bad_type_byte();
    send_byte(stx_pkg::BYTE_START);
    send_byte(8'h77);
    send_byte(stx_pkg::BYTE_START);
    send_byte(stx_pkg::BYTE_START);
    send_byte(8'h55);
  endtask

  // A start byte in the end position opens a new frame, dropped here by type.
  task automatic test_missing_end_byte();
    send_frame(1'b0, stx_pkg::BYTE_START);
    send_byte(8'h77);
  endtask

  // Mostly well-formed frames, with broken frames and line noise mixed in.
  task automatic test_random_traffic(input int unsigned target, input int unsigned gap,
                                     input int unsigned stall);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  b;
    gap_pct   = gap;
    stall_pct = stall;
    start     = live_bytes;
    while (live_bytes - start < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_frame(1'b0, stx_pkg::BYTE_END);
      end else if (pick < 65) begin
        send_frame(1'b1, stx_pkg::BYTE_END);
      end else if (pick < 75) begin
        b = ($urandom_range(1) != 0) ? stx_pkg::BYTE_START : 8'($urandom_range(255));
        if (b == stx_pkg::BYTE_END) b = 8'h00;
        send_frame(1'($urandom_range(1)), b);
      end else if (pick < 85) begin
        b = 8'($urandom_range(255));
        if (b == stx_pkg::TYPE_ID || b == stx_pkg::TYPE_DATA) b = 8'h77;
        send_byte(stx_pkg::BYTE_START);
        send_byte(b);
      end else begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
      end
    end
    hold_until_drained();
  endtask

  // Reset, directed checks, then random traffic under each idling pattern.
  initial begin
    rx_phase     = stx_pkg::PhHunt;
    held_kind    = 1'b0;
    stored_count = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    live_bytes   = 0;
    cycle_count  = 0;
    error_count  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_hunt_ignores_noise();
    test_id_frame_extremes();
    test_bad_type_byte();
    test_missing_end_byte();
    hold_until_drained();

    test_random_traffic(90, 0, 0);
    test_random_traffic(90, 79, 0);
    test_random_traffic(90, 0, 79);
    test_random_traffic(90, 14, 14);

    error_count += pending_beats.size();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/stx_pkg.sv
src/stx_front.sv
src/stx_fifo.sv
src/stx_store.sv
src/stx_back.sv
src/stx_etx_tag_frame_parser_unit.sv
src/stx_checker.sv
tb/sv/stx_etx_tag_frame_parser_unit_tb.sv
